// ----- rtl/drt_pkg.sv -----
// Shared types and codes for the device roster table.
// Used by drt_entry_ram and device_roster_table; depends on nothing.
`timescale 1ns / 1ps

package drt_pkg;

	// Request codes
	localparam logic [1:0] REQ_ENROL  = 2'd0;
	localparam logic [1:0] REQ_FORGET = 2'd1;
	localparam logic [1:0] REQ_PAIR   = 2'd2;
	localparam logic [1:0] REQ_LOOKUP = 2'd3;

	// Result status codes
	localparam logic [1:0] RES_OK      = 2'd0;
	localparam logic [1:0] RES_ZERO_ID = 2'd1;
	localparam logic [1:0] RES_NO_ROOM = 2'd2;

	// Entry state codes
	localparam logic [1:0] DEV_FREE     = 2'd0;
	localparam logic [1:0] DEV_ENROLLED = 2'd1;
	localparam logic [1:0] DEV_PAIRED   = 2'd2;

	// Width of a stored radio slot
	localparam int SLOT_W = 5;

	// One stored entry record (state is kept apart in flops)
	typedef struct packed {
		logic [31:0]       id;
		logic [SLOT_W-1:0] slot;
		logic [31:0]       keygen;
		logic [31:0]       epoch;
		logic [63:0]       nonce;
	} entry_t;

endpackage

// ----- rtl/drt_entry_ram.sv -----
// Entry record memory: one write port, one read port with registered data.
// Depends on drt_pkg for the entry record type.
`timescale 1ns / 1ps

module drt_entry_ram #(
	parameter int DEPTH = 32,
	parameter int AW = 5
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  drt_pkg::entry_t wr_data,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output drt_pkg::entry_t rd_data
);
	import drt_pkg::*;

	entry_t mem [DEPTH];

	// Write the addressed record
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Register the read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/device_roster_table.sv -----
// Device roster table top level: request sequencer, entry state flops, slot map.
// Depends on drt_pkg and drt_entry_ram.
`timescale 1ns / 1ps

// Usage
// One request enters on the input channel (in_valid / in_ready) as req_type,
// dev_id, epoch_in and nonce; exactly one result leaves on the output
// channel (out_valid / out_ready) as status, radio_slot, key_generation,
// dev_state and epoch_out. in_ready is high only while the sequencer is idle.
// Each request walks all ENTRIES records of the entry memory, one read per
// cycle on its single read port, collecting the matching live entry, the first
// free entry and the map of used radio slots. A new-id enrol then tests the
// slot map one slot per cycle, up to min(ENTRIES, RADIO_SLOTS, 32) slots. The
// result is then loaded into the output register, and the sequencer returns to
// idle before it accepts the next request. The output register holds a result
// until taken; the next request may be accepted meanwhile, and its result
// waits in the sequencer if the receiver still stalls. Reset marks every entry
// free and empties the output register; record contents are not cleared, as
// the scan ignores the record of a free entry.
module device_roster_table #(
	parameter int ENTRIES = 32,
	parameter int RADIO_SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] dev_id,
	input  logic [31:0] epoch_in,
	input  logic [63:0] nonce,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [4:0]  radio_slot,
	output logic [31:0] key_generation,
	output logic [1:0]  dev_state,
	output logic [31:0] epoch_out
);
	import drt_pkg::*;

	localparam int EIW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ECW = $clog2(ENTRIES + 1);
	localparam int SLOT_LIM0 = (ENTRIES < 32) ? ENTRIES : 32;
	localparam int SLOT_LIM = (RADIO_SLOTS < SLOT_LIM0) ? RADIO_SLOTS : SLOT_LIM0;
	localparam int SIW = (SLOT_LIM > 1) ? $clog2(SLOT_LIM) : 1;
	localparam int SCW = $clog2(SLOT_LIM + 1);
	localparam logic [ECW-1:0] ENTRY_END = ECW'(ENTRIES);
	localparam logic [SCW-1:0] SLOT_END = SCW'(SLOT_LIM);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_SLOT,
		ST_RESP
	} fsm_t;

	fsm_t state_q;

	// Latched request
	logic [1:0]  req_q;
	logic [31:0] id_q;
	logic [31:0] epoch_q;
	logic [63:0] nonce_q;

	// Entry states, reset to free
	logic [1:0] dev_st_q [ENTRIES];

	// Scan bookkeeping
	logic [ECW-1:0] scan_cnt_q;
	logic           rd_vld_s1;
	logic [EIW-1:0] rd_idx_s1;
	logic           hit_q;
	logic [EIW-1:0] hit_idx_q;
	entry_t         hit_ent_q;
	logic           free_found_q;
	logic [EIW-1:0] free_idx_q;
	logic [SLOT_LIM-1:0] used_q;
	logic [SCW-1:0] slot_cnt_q;

	// Pending result
	logic [1:0]  res_status_q;
	logic [4:0]  res_slot_q;
	logic [31:0] res_keygen_q;
	logic [1:0]  res_state_q;
	logic [31:0] res_epoch_q;

	// Memory ports
	logic           wr_en_q;
	logic [EIW-1:0] wr_addr_q;
	entry_t         wr_data_q;
	logic           rd_en;
	entry_t         rd_data;

	logic           scan_live;
	entry_t         upd_ent;
	logic [1:0]     upd_st;
	logic           upd_write;
	logic [4:0]     slot5;

	assign in_ready = (state_q == ST_IDLE);
	assign rd_en = (state_q == ST_SCAN) && (scan_cnt_q < ENTRY_END);
	assign scan_live = (dev_st_q[rd_idx_s1] != DEV_FREE);
	assign slot5 = 5'(slot_cnt_q);

	drt_entry_ram #(
		.DEPTH(ENTRIES),
		.AW(EIW)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en_q),
		.wr_addr(wr_addr_q),
		.wr_data(wr_data_q),
		.rd_en(rd_en),
		.rd_addr(scan_cnt_q[EIW-1:0]),
		.rd_data(rd_data)
	);

	// Apply the request to the matching entry
	always_comb begin
		upd_ent = hit_ent_q;
		upd_st = dev_st_q[hit_idx_q];
		upd_write = 1'b0;
		case (req_q)
			REQ_ENROL: begin
				upd_ent.keygen = hit_ent_q.keygen + 32'd1;
				upd_st = DEV_ENROLLED;
				upd_write = 1'b1;
			end
			REQ_FORGET: begin
				upd_st = DEV_FREE;
			end
			REQ_PAIR: begin
				upd_ent.epoch = epoch_q;
				upd_ent.nonce = nonce_q;
				upd_st = DEV_PAIRED;
				upd_write = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer, entry states and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			wr_en_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				dev_st_q[i] <= DEV_FREE;
			end
		end else begin
			// Drop the write strobe outside the states that may raise it
			if (state_q != ST_DECIDE && state_q != ST_SLOT) begin
				wr_en_q <= 1'b0;
			end
			// Drop the result once taken, unless a new one loads this cycle
			if (out_valid && out_ready && state_q != ST_RESP) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q <= req_type;
						id_q <= dev_id;
						epoch_q <= epoch_in;
						nonce_q <= nonce;
						scan_cnt_q <= '0;
						rd_vld_s1 <= 1'b0;
						hit_q <= 1'b0;
						free_found_q <= 1'b0;
						used_q <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// Issue the next read
					rd_vld_s1 <= rd_en;
					rd_idx_s1 <= scan_cnt_q[EIW-1:0];
					if (rd_en) begin
						scan_cnt_q <= scan_cnt_q + 1'b1;
					end
					// Examine the record read last cycle
					if (rd_vld_s1) begin
						if (scan_live && rd_data.id == id_q && !hit_q) begin
							hit_q <= 1'b1;
							hit_idx_q <= rd_idx_s1;
							hit_ent_q <= rd_data;
						end
						if (!scan_live && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q <= rd_idx_s1;
						end
						if (scan_live && (32'(rd_data.slot) < SLOT_LIM)) begin
							used_q[rd_data.slot[SIW-1:0]] <= 1'b1;
						end
					end
					if (!rd_en && !rd_vld_s1) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (req_q == REQ_ENROL && id_q == 32'd0) begin
						wr_en_q <= 1'b0;
						res_status_q <= RES_ZERO_ID;
						res_slot_q <= '0;
						res_keygen_q <= '0;
						res_state_q <= DEV_FREE;
						res_epoch_q <= '0;
						state_q <= ST_RESP;
					end else if (hit_q) begin
						dev_st_q[hit_idx_q] <= upd_st;
						wr_en_q <= upd_write;
						wr_addr_q <= hit_idx_q;
						wr_data_q <= upd_ent;
						res_status_q <= RES_OK;
						res_slot_q <= upd_ent.slot;
						res_keygen_q <= upd_ent.keygen;
						res_state_q <= upd_st;
						res_epoch_q <= upd_ent.epoch;
						state_q <= ST_RESP;
					end else if (req_q != REQ_ENROL || !free_found_q) begin
						wr_en_q <= 1'b0;
						res_status_q <= RES_NO_ROOM;
						res_slot_q <= '0;
						res_keygen_q <= '0;
						res_state_q <= DEV_FREE;
						res_epoch_q <= '0;
						state_q <= ST_RESP;
					end else begin
						wr_en_q <= 1'b0;
						slot_cnt_q <= '0;
						state_q <= ST_SLOT;
					end
				end
				ST_SLOT: begin
					// Test one slot of the map per cycle
					if (slot_cnt_q == SLOT_END) begin
						wr_en_q <= 1'b0;
						res_status_q <= RES_NO_ROOM;
						res_slot_q <= '0;
						res_keygen_q <= '0;
						res_state_q <= DEV_FREE;
						res_epoch_q <= '0;
						state_q <= ST_RESP;
					end else if (!used_q[slot_cnt_q[SIW-1:0]]) begin
						dev_st_q[free_idx_q] <= DEV_ENROLLED;
						wr_en_q <= 1'b1;
						wr_addr_q <= free_idx_q;
						wr_data_q.id <= id_q;
						wr_data_q.slot <= slot5;
						wr_data_q.keygen <= 32'd1;
						wr_data_q.epoch <= '0;
						wr_data_q.nonce <= '0;
						res_status_q <= RES_OK;
						res_slot_q <= slot5;
						res_keygen_q <= 32'd1;
						res_state_q <= DEV_ENROLLED;
						res_epoch_q <= '0;
						state_q <= ST_RESP;
					end else begin
						wr_en_q <= 1'b0;
						slot_cnt_q <= slot_cnt_q + 1'b1;
					end
				end
				ST_RESP: begin
					// Hold the result until the output register is free
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						status <= res_status_q;
						radio_slot <= res_slot_q;
						key_generation <= res_keygen_q;
						dev_state <= res_state_q;
						epoch_out <= res_epoch_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for device_roster_table: directed and random requests,
// with a shadow roster predicting every result. Depends on drt_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
	import drt_pkg::*;

	localparam int ENTRIES     = 32;
	localparam int RADIO_SLOTS = 32;
	localparam int CYCLE_LIMIT = 1500000;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  slot;
		logic [31:0] keygen;
		logic [1:0]  state;
		logic [31:0] epoch;
	} report_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  req_type;
	logic [31:0] dev_id;
	logic [31:0] epoch_in;
	logic [63:0] nonce;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [4:0]  radio_slot;
	logic [31:0] key_generation;
	logic [1:0]  dev_state;
	logic [31:0] epoch_out;

	// Shadow roster
	logic [31:0] shadow_id     [ENTRIES];
	logic [4:0]  shadow_slot   [ENTRIES];
	logic [31:0] shadow_keygen [ENTRIES];
	logic [1:0]  shadow_state  [ENTRIES];
	logic [31:0] shadow_epoch  [ENTRIES];
	logic [63:0] shadow_nonce  [ENTRIES];

	report_t     expected_reports[$];
	logic [31:0] id_pool[48];
	int          fail_count = 0;
	int          cycle_count = 0;
	int          rx_hold_cycles = 0;
	bit          tx_steady = 1'b0;
	bit          rx_steady = 1'b0;

	device_roster_table #(
		.ENTRIES(ENTRIES),
		.RADIO_SLOTS(RADIO_SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.dev_id(dev_id),
		.epoch_in(epoch_in),
		.nonce(nonce),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.radio_slot(radio_slot),
		.key_generation(key_generation),
		.dev_state(dev_state),
		.epoch_out(epoch_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one request to the shadow roster and return the report it yields
	function automatic report_t apply_request(logic [1:0] req, logic [31:0] id,
			logic [31:0] epoch, logic [63:0] nc);
		int      hit;
		int      vacant;
		int      open_slot;
		int      limit;
		int      i;
		int      s;
		bit      used;
		report_t r;
		hit = -1;
		vacant = -1;
		open_slot = -1;
		r = '0;
		for (i = 0; i < ENTRIES; i++)
			if (hit < 0 && shadow_state[i] != DEV_FREE && shadow_id[i] == id)
				hit = i;
		if (req == REQ_ENROL) begin
			if (id == 32'd0) begin
				r.status = RES_ZERO_ID;
				return r;
			end
			if (hit >= 0) begin
				shadow_keygen[hit] = shadow_keygen[hit] + 32'd1;
				shadow_state[hit] = DEV_ENROLLED;
			end else begin
				for (i = 0; i < ENTRIES; i++)
					if (vacant < 0 && shadow_state[i] == DEV_FREE)
						vacant = i;
				limit = 32;
				if (ENTRIES < limit)
					limit = ENTRIES;
				if (RADIO_SLOTS < limit)
					limit = RADIO_SLOTS;
				for (s = 0; s < limit; s++) begin
					if (open_slot < 0) begin
						used = 1'b0;
						for (i = 0; i < ENTRIES; i++)
							if (shadow_state[i] != DEV_FREE && int'(shadow_slot[i]) == s)
								used = 1'b1;
						if (!used)
							open_slot = s;
					end
				end
				if (vacant < 0 || open_slot < 0) begin
					r.status = RES_NO_ROOM;
					return r;
				end
				hit = vacant;
				shadow_id[hit] = id;
				shadow_slot[hit] = open_slot[4:0];
				shadow_keygen[hit] = 32'd1;
				shadow_state[hit] = DEV_ENROLLED;
				shadow_epoch[hit] = 32'd0;
				shadow_nonce[hit] = 64'd0;
			end
		end else begin
			if (hit < 0) begin
				r.status = RES_NO_ROOM;
				return r;
			end
			case (req)
				REQ_FORGET: begin
					shadow_state[hit] = DEV_FREE;
				end
				REQ_PAIR: begin
					shadow_state[hit] = DEV_PAIRED;
					shadow_epoch[hit] = epoch;
					shadow_nonce[hit] = nc;
				end
				default: begin
				end
			endcase
		end
		r.status = RES_OK;
		r.slot = shadow_slot[hit];
		r.keygen = shadow_keygen[hit];
		r.state = shadow_state[hit];
		r.epoch = shadow_epoch[hit];
		return r;
	endfunction

	// Pick an id: often a live one, else from the pool, sometimes zero or fully random
	function automatic logic [31:0] pick_id(int live_pct);
		int live[$];
		int i;
		int roll;
		for (i = 0; i < ENTRIES; i++)
			if (shadow_state[i] != DEV_FREE)
				live.push_back(i);
		if (live.size() > 0 && $urandom_range(99) < live_pct)
			return shadow_id[live[$urandom_range(live.size() - 1)]];
		roll = $urandom_range(99);
		if (roll < 4)
			return 32'd0;
		if (roll < 10)
			return $urandom;
		return id_pool[$urandom_range(47)];
	endfunction

	// Offer one transaction and record its expected report on acceptance
	task automatic send_request(logic [1:0] req, logic [31:0] id, logic [31:0] epoch,
			logic [63:0] nc);
		int gap;
		gap = 0;
		if (!tx_steady && $urandom_range(99) < 31)
			gap = $urandom_range(1, 110);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		dev_id <= id;
		epoch_in <= epoch;
		nonce <= nc;
		do
			@(posedge clk);
		while (!in_ready);
		expected_reports.push_back(apply_request(req, id, epoch, nc));
	endtask

	task automatic random_request(int enrol_pct);
		logic [1:0] req;
		if ($urandom_range(99) < enrol_pct) begin
			req = REQ_ENROL;
			send_request(req, pick_id(30), $urandom, {$urandom, $urandom});
		end else begin
			case ($urandom_range(2))
				0: req = REQ_FORGET;
				1: req = REQ_PAIR;
				default: req = REQ_LOOKUP;
			endcase
			send_request(req, pick_id(70), $urandom, {$urandom, $urandom});
		end
	endtask

	// Drop valid and hold off until every expected report has come back
	task automatic wait_reports_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_request(REQ_LOOKUP, 32'd0, 32'd0, 64'd0);
		send_request(REQ_FORGET, 32'h1234_5678, 32'd0, 64'd0);
		send_request(REQ_PAIR, 32'h1234_5678, 32'hFFFF_FFFF, '1);
		send_request(REQ_ENROL, 32'd0, 32'hFFFF_FFFF, '1);
		send_request(REQ_ENROL, 32'hFFFF_FFFF, 32'd0, 64'd0);
		send_request(REQ_ENROL, 32'd1, 32'd0, 64'd0);
		send_request(REQ_ENROL, 32'hFFFF_FFFF, 32'd0, 64'd0);
		send_request(REQ_PAIR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
		send_request(REQ_ENROL, 32'hFFFF_FFFF, 32'd0, 64'd0);
		send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'd0, 64'd0);
		send_request(REQ_FORGET, 32'd1, 32'd0, 64'd0);
		send_request(REQ_FORGET, 32'd1, 32'd0, 64'd0);
		send_request(REQ_LOOKUP, 32'd1, 32'd0, 64'd0);
		send_request(REQ_ENROL, 32'd5, 32'd0, 64'd0);
		send_request(REQ_PAIR, 32'd5, 32'd0, 64'd0);
		send_request(REQ_ENROL, 32'h8000_0000, 32'd0, 64'd0);
		send_request(REQ_FORGET, 32'hFFFF_FFFF, 32'd0, 64'd0);
		send_request(REQ_ENROL, 32'h0000_0002, 32'd0, 64'd0);
		send_request(REQ_LOOKUP, 32'd0, 32'd0, 64'd0);
		send_request(REQ_PAIR, 32'd0, 32'h5555_AAAA, 64'hAAAA_5555_AAAA_5555);
		wait_reports_drained();
	endtask

	// Fill every entry, overflow it, then forget everything live
	task automatic test_table_full();
		int k;
		for (k = 0; k < ENTRIES + 2; k++)
			send_request(REQ_ENROL, 32'hA500_0000 + k, $urandom, {$urandom, $urandom});
		send_request(REQ_LOOKUP, 32'hA500_0000, 32'd0, 64'd0);
		for (k = 0; k < ENTRIES; k++)
			if (shadow_state[k] != DEV_FREE)
				send_request(REQ_FORGET, shadow_id[k], 32'd0, 64'd0);
		wait_reports_drained();
	endtask

	// Stall the receiver long enough that the block backs up into its input
	task automatic test_backpressure();
		int k;
		rx_hold_cycles = 800;
		for (k = 0; k < 12; k++)
			random_request(60);
		wait_reports_drained();
	endtask

	task automatic test_no_idle();
		int k;
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		for (k = 0; k < 150; k++)
			random_request(45);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// Alternate fill-heavy and drain-heavy mixes so the table both fills and empties
	task automatic test_random();
		int k;
		for (k = 0; k < 250; k++)
			random_request(60);
		for (k = 0; k < 250; k++)
			random_request(20);
		for (k = 0; k < 250; k++)
			random_request(50);
		for (k = 0; k < 200; k++)
			random_request(35);
	endtask

	// Receiver: random stalls, occasional long ones, and the forced hold-off
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				out_ready <= 1'b0;
				rx_hold_cycles = rx_hold_cycles - 1;
			end else if (rx_steady) begin
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left = stall_left - 1;
			end else if ($urandom_range(99) < 31) begin
				out_ready <= 1'b0;
				if ($urandom_range(99) < 3)
					stall_left = $urandom_range(10, 120);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compare each accepted result with the oldest expected report
	always @(posedge clk) begin
		report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_reports.size() == 0) begin
				$error("unexpected result: status %0d slot %0d", status, radio_slot);
				fail_count++;
			end else begin
				want = expected_reports.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
				if (radio_slot !== want.slot) begin
					$error("radio_slot: expected %0d, got %0d", want.slot, radio_slot);
					fail_count++;
				end
				if (key_generation !== want.keygen) begin
					$error("key_generation: expected %0h, got %0h", want.keygen,
						key_generation);
					fail_count++;
				end
				if (dev_state !== want.state) begin
					$error("dev_state: expected %0d, got %0d", want.state, dev_state);
					fail_count++;
				end
				if (epoch_out !== want.epoch) begin
					$error("epoch_out: expected %0h, got %0h", want.epoch, epoch_out);
					fail_count++;
				end
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int k;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_ENROL;
		dev_id = 32'd0;
		epoch_in = 32'd0;
		nonce = 64'd0;
		for (k = 0; k < ENTRIES; k++) begin
			shadow_id[k] = 32'd0;
			shadow_slot[k] = 5'd0;
			shadow_keygen[k] = 32'd0;
			shadow_state[k] = DEV_FREE;
			shadow_epoch[k] = 32'd0;
			shadow_nonce[k] = 64'd0;
		end
		id_pool[0] = 32'hFFFF_FFFF;
		id_pool[1] = 32'd1;
		for (k = 2; k < 48; k++)
			id_pool[k] = $urandom;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_table_full();
		test_backpressure();
		test_no_idle();
		test_random();

		wait_reports_drained();
		repeat (120) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
